### rtl/core/prrp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the priority round-robin picker.
// No dependencies; imported by the core, the checker and the testbench.
package prrp_pkg;

  localparam int NUM_SLOTS_DEF = 64;
  localparam int PRIO_W        = 6;
  localparam int IDX_OUT_W     = 6;

  localparam logic [PRIO_W-1:0] CEILING_RESET = 6'd19;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PICK  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BEST,
    ST_SCAN,
    ST_FINISH
  } prrp_state_t;

endpackage

### rtl/core/prrp_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module prrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/priority_round_robin_picker_core.sv
`timescale 1ns / 1ps
// Top level of the priority round-robin picker: sequencer, slot table RAM, result register.
// Depends on prrp_pkg and prrp_ram.
//
// Strict-priority round-robin picker. Slots live in one RAM ({runnable, priority}) that is
// read one entry per cycle. After reset the table is cleared one entry a cycle, and in_ready
// stays low until the clear is done (configuration writes are still taken). A write item goes
// through ST_IDLE and ST_FINISH. A pick item makes one pass over the RAM to find the best
// priority at or below the priority ceiling, then a round-robin pass starting after the last
// pick that stops at the first qualifying slot. Both passes are bound by the single RAM read
// port. Every item yields one result; the result register lets the next item start while a
// result still waits on out_ready.
module priority_round_robin_picker_core
  import prrp_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 opcode,
  input  logic [5:0]           slot_index,
  input  logic                 slot_runnable,
  input  logic [PRIO_W-1:0]    slot_priority,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 picked_valid,
  output logic [IDX_OUT_W-1:0] picked_index,
  output logic [PRIO_W-1:0]    picked_priority,
  input  logic                 cfg_wr_en,
  input  logic [PRIO_W-1:0]    cfg_wr_data
);

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int ENT_W = PRIO_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_SLOTS - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(NUM_SLOTS);

  prrp_state_t state, state_next;

  logic [CNT_W-1:0]     cnt, cnt_next;
  logic [IDX_W-1:0]     pos_iss, pos_iss_next;
  logic [IDX_W-1:0]     pos_dat, pos_dat_next;
  logic [IDX_W-1:0]     ptr, ptr_next;
  logic [PRIO_W-1:0]    best, best_next;
  logic [PRIO_W-1:0]    ceiling;
  logic                 res_valid, res_valid_next;
  logic [IDX_OUT_W-1:0] res_idx, res_idx_next;
  logic [PRIO_W-1:0]    res_prio, res_prio_next;
  logic                 load_out;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENT_W-1:0]     ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [ENT_W-1:0]     ram_rdata;

  logic                 rd_run;
  logic [PRIO_W-1:0]    rd_prio;
  logic                 wr_in_range;
  logic [IDX_W-1:0]     ptr_wrap;
  logic [IDX_W-1:0]     pos_iss_wrap;

  assign rd_run       = ram_rdata[ENT_W-1];
  assign rd_prio      = ram_rdata[PRIO_W-1:0];
  assign wr_in_range  = 32'(slot_index) < NUM_SLOTS;
  assign ptr_wrap     = (ptr == LAST_IDX) ? '0 : ptr + 1'b1;
  assign pos_iss_wrap = (pos_iss == LAST_IDX) ? '0 : pos_iss + 1'b1;

  prrp_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= '0;
      ptr       <= LAST_IDX;
      ceiling   <= CEILING_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      ptr   <= ptr_next;
      if (cfg_wr_en) begin
        ceiling <= cfg_wr_data;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    pos_iss   <= pos_iss_next;
    pos_dat   <= pos_dat_next;
    best      <= best_next;
    res_valid <= res_valid_next;
    res_idx   <= res_idx_next;
    res_prio  <= res_prio_next;
    if (load_out) begin
      picked_valid    <= res_valid;
      picked_index    <= res_idx;
      picked_priority <= res_prio;
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    pos_iss_next   = pos_iss;
    pos_dat_next   = pos_dat;
    ptr_next       = ptr;
    best_next      = best;
    res_valid_next = res_valid;
    res_idx_next   = res_idx;
    res_prio_next  = res_prio;
    load_out       = 1'b0;
    in_ready       = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = pos_iss;

    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt[IDX_W-1:0];
        if (cnt == CNT_LAST) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (opcode == OP_WRITE) begin
            ram_we         = wr_in_range;
            ram_waddr      = IDX_W'(slot_index);
            ram_wdata      = {slot_runnable, slot_priority};
            res_valid_next = 1'b0;
            res_idx_next   = '0;
            res_prio_next  = '0;
            state_next     = ST_FINISH;
          end else begin
            best_next  = ceiling;
            cnt_next   = '0;
            state_next = ST_BEST;
          end
        end
      end

      // pass 1: read slot cnt, evaluate the slot read in the previous cycle
      ST_BEST: begin
        ram_raddr = (cnt < CNT_END) ? cnt[IDX_W-1:0] : '0;
        if (cnt != '0 && rd_run && rd_prio < best) begin
          best_next = rd_prio;
        end
        if (cnt == CNT_END) begin
          cnt_next     = '0;
          pos_iss_next = ptr_wrap;
          state_next   = ST_SCAN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      // pass 2: round-robin from the slot after the pointer, first hit wins
      ST_SCAN: begin
        ram_raddr    = pos_iss;
        pos_iss_next = pos_iss_wrap;
        pos_dat_next = pos_iss;
        cnt_next     = cnt + 1'b1;
        if (cnt != '0 && rd_run && rd_prio <= best) begin
          res_valid_next = 1'b1;
          res_idx_next   = IDX_OUT_W'(pos_dat);
          res_prio_next  = rd_prio;
          ptr_next       = pos_dat;
          state_next     = ST_FINISH;
        end else if (cnt == CNT_END) begin
          res_valid_next = 1'b0;
          res_idx_next   = '0;
          res_prio_next  = '0;
          state_next     = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/prrp_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the priority round-robin picker, bound to the top level.
// Depends on prrp_pkg and priority_round_robin_picker_core.
module prrp_checker
  import prrp_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              picked_valid,
  input logic [5:0]        picked_index,
  input logic [PRIO_W-1:0] picked_priority,
  input logic              cfg_wr_en,
  input logic [PRIO_W-1:0] cfg_wr_data
);

  logic [PRIO_W-1:0] ceil_shadow;

  always_ff @(posedge clk) begin
    if (rst) begin
      ceil_shadow <= CEILING_RESET;
    end else if (cfg_wr_en) begin
      ceil_shadow <= cfg_wr_data;
    end
  end

  // table clear runs right after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("in_ready high right after reset");

  // one item in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high in the cycle after a transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(picked_valid)
      && $stable(picked_index) && $stable(picked_priority)))
    else $error("result changed while stalled");

  a_no_pick_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !picked_valid) |-> (picked_index == '0 && picked_priority == '0))
    else $error("empty result carries nonzero fields");

  a_under_ceiling: assert property (@(posedge clk) disable iff (rst)
    (out_valid && picked_valid) |-> (picked_priority <= ceil_shadow))
    else $error("picked slot above priority ceiling");

endmodule

bind priority_round_robin_picker_core prrp_checker u_prrp_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .picked_valid    (picked_valid),
  .picked_index    (picked_index),
  .picked_priority (picked_priority),
  .cfg_wr_en       (cfg_wr_en),
  .cfg_wr_data     (cfg_wr_data)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for priority_round_robin_picker_core: directed table, then random
// slot writes and picks under several priority ceilings, random gaps and stalls.
// Depends on prrp_pkg and the picker RTL.
module testbench;
  import prrp_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam bit CHK_MODEL   = 1'b0;
  localparam bit CHK_FIXED   = 1'b1;

  typedef struct packed {
    logic              hit;
    logic [5:0]        slot;
    logic [PRIO_W-1:0] prio;
  } pick_t;

  localparam pick_t NO_PICK = '0;

  typedef struct packed {
    logic              op;
    logic [5:0]        slot;
    logic              run;
    logic [PRIO_W-1:0] prio;
    logic              chk;
    pick_t             res;
  } dir_row_t;

  // Ceiling is at reset value 19 and the pointer at the last slot for this table.
  localparam dir_row_t DIRECTED [24] = '{
    '{OP_PICK,  6'd0,  1'b0, 6'd0,  CHK_FIXED, NO_PICK}, // empty table after reset
    '{OP_WRITE, 6'd0,  1'b1, 6'd0,  CHK_FIXED, NO_PICK},
    '{OP_WRITE, 6'd63, 1'b1, 6'd63, CHK_FIXED, NO_PICK},
    '{OP_PICK,  6'd0,  1'b0, 6'd0,  CHK_MODEL, NO_PICK}, // wraps from last slot to 0
    '{OP_PICK,  6'd0,  1'b0, 6'd0,  CHK_MODEL, NO_PICK}, // pointer slot is the only one
    '{OP_WRITE, 6'd0,  1'b0, 6'd0,  CHK_FIXED, NO_PICK},
    '{OP_PICK,  6'd0,  1'b0, 6'd0,  CHK_FIXED, NO_PICK}, // only runnable slot above ceiling
    '{OP_WRITE, 6'd5,  1'b1, 6'd19, CHK_FIXED, NO_PICK},
    '{OP_PICK,  6'd0,  1'b0, 6'd0,  CHK_MODEL, NO_PICK}, // tie at ceiling
    '{OP_WRITE, 6'd10, 1'b1, 6'd19, CHK_FIXED, NO_PICK},
    '{OP_PICK,  6'd0,  1'b0, 6'd0,  CHK_MODEL, NO_PICK},
    '{OP_PICK,  6'd0,  1'b0, 6'd0,  CHK_MODEL, NO_PICK},
    '{OP_WRITE, 6'd3,  1'b1, 6'd7,  CHK_FIXED, NO_PICK},
    '{OP_WRITE, 6'd41, 1'b0, 6'd0,  CHK_FIXED, NO_PICK},
    '{OP_WRITE, 6'd42, 1'b1, 6'd7,  CHK_FIXED, NO_PICK},
    '{OP_PICK,  6'd0,  1'b0, 6'd0,  CHK_MODEL, NO_PICK},
    '{OP_PICK,  6'd0,  1'b0, 6'd0,  CHK_MODEL, NO_PICK},
    '{OP_WRITE, 6'd63, 1'b1, 6'd0,  CHK_FIXED, NO_PICK},
    '{OP_PICK,  6'd0,  1'b0, 6'd0,  CHK_MODEL, NO_PICK},
    '{OP_WRITE, 6'd62, 1'b1, 6'd20, CHK_FIXED, NO_PICK},
    '{OP_PICK,  6'd0,  1'b0, 6'd0,  CHK_MODEL, NO_PICK},
    '{OP_WRITE, 6'd63, 1'b0, 6'd63, CHK_FIXED, NO_PICK},
    '{OP_PICK,  6'd0,  1'b0, 6'd0,  CHK_MODEL, NO_PICK},
    '{OP_PICK,  6'd63, 1'b1, 6'd63, CHK_MODEL, NO_PICK}  // ignored fields all ones
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              opcode = OP_WRITE;
  logic [5:0]        slot_index = '0;
  logic              slot_runnable = 1'b0;
  logic [PRIO_W-1:0] slot_priority = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              picked_valid;
  logic [5:0]        picked_index;
  logic [PRIO_W-1:0] picked_priority;
  logic              cfg_wr_en = 1'b0;
  logic [PRIO_W-1:0] cfg_wr_data = '0;

  // shadow of the slot table, pointer and ceiling
  logic              slot_run  [NUM_SLOTS_DEF];
  logic [PRIO_W-1:0] slot_prio [NUM_SLOTS_DEF];
  int                rr_ptr;
  logic [PRIO_W-1:0] ceiling_now;

  pick_t             pending_picks [$];
  int                mismatches = 0;
  int                idle_cycles = 0;
  bit                burst_mode = 1'b0;
  logic [5:0]        hot_slots [8];

  priority_round_robin_picker_core #(
    .NUM_SLOTS(NUM_SLOTS_DEF)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .slot_index(slot_index),
    .slot_runnable(slot_runnable),
    .slot_priority(slot_priority),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .picked_valid(picked_valid),
    .picked_index(picked_index),
    .picked_priority(picked_priority),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Updates the shadow table and returns what the block should report for this item.
  function automatic pick_t apply_item(logic op, logic [5:0] idx, logic run,
                                       logic [PRIO_W-1:0] prio);
    pick_t             res;
    logic [PRIO_W-1:0] best;
    int                pos;
    res = NO_PICK;
    if (op == OP_WRITE) begin
      if (idx < NUM_SLOTS_DEF) begin
        slot_run[idx]  = run;
        slot_prio[idx] = prio;
      end
      return res;
    end
    best = ceiling_now;
    for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
      if (slot_run[i] && slot_prio[i] < best) best = slot_prio[i];
    end
    pos = rr_ptr;
    for (int k = 0; k < NUM_SLOTS_DEF; k++) begin
      pos = (pos + 1) % NUM_SLOTS_DEF;
      if (slot_run[pos] && slot_prio[pos] <= best) begin
        rr_ptr   = pos;
        res.hit  = 1'b1;
        res.slot = 6'(pos);
        res.prio = slot_prio[pos];
        return res;
      end
    end
    return res;
  endfunction

  task automatic send_item(logic op, logic [5:0] idx, logic run, logic [PRIO_W-1:0] prio,
                           logic chk, pick_t fixed_res);
    pick_t res;
    int    gap;
    in_valid      <= 1'b1;
    opcode        <= op;
    slot_index    <= idx;
    slot_runnable <= run;
    slot_priority <= prio;
    do @(posedge clk); while (!in_ready);
    res = apply_item(op, idx, run, prio);
    pending_picks.push_back(chk == CHK_FIXED ? fixed_res : res);
    gap = burst_mode ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Only while idle: drain, let the last item settle, then write.
  task automatic write_ceiling(logic [PRIO_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    ceiling_now = value;
  endtask

  task automatic run_random(int count);
    logic              op;
    logic [5:0]        idx;
    logic              run;
    logic [PRIO_W-1:0] prio;
    int                near;
    for (int i = 0; i < 8; i++) hot_slots[i] = 6'($urandom);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 29) == 0) burst_mode = ~burst_mode;
      op  = ($urandom_range(0, 99) < 35) ? OP_PICK : OP_WRITE;
      // a small hot set keeps several slots competing, often at the same priority
      idx = $urandom_range(0, 1) ? hot_slots[$urandom_range(0, 7)] : 6'($urandom);
      run = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) begin
        prio = 6'($urandom);
      end else begin
        near = int'(ceiling_now) + int'($urandom_range(0, 6)) - 4;
        if (near < 0) near = 0;
        if (near > 63) near = 63;
        prio = 6'(near);
      end
      send_item(op, idx, run, prio, CHK_MODEL, NO_PICK);
    end
  endtask

  // result side: random stall per result, check against oldest expectation
  initial begin
    pick_t want;
    int    stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_picks.size() == 0) begin
        report_mismatch($sformatf("unrequested transfer: valid %0d slot %0d prio %0d",
                                  picked_valid, picked_index, picked_priority));
      end else begin
        want = pending_picks.pop_front();
        if (picked_valid !== want.hit)
          report_mismatch($sformatf("picked_valid got %0d want %0d", picked_valid, want.hit));
        if (picked_index !== want.slot)
          report_mismatch($sformatf("picked_index got %0d want %0d", picked_index, want.slot));
        if (picked_priority !== want.prio)
          report_mismatch($sformatf("picked_priority got %0d want %0d",
                                    picked_priority, want.prio));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [PRIO_W-1:0] plan [6];
    for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
      slot_run[i]  = 1'b0;
      slot_prio[i] = '0;
    end
    rr_ptr      = NUM_SLOTS_DEF - 1;
    ceiling_now = CEILING_RESET;
    plan = '{6'd63, 6'd0, 6'($urandom), CEILING_RESET, 6'($urandom), 6'd32};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i])
      send_item(DIRECTED[i].op, DIRECTED[i].slot, DIRECTED[i].run, DIRECTED[i].prio,
                DIRECTED[i].chk, DIRECTED[i].res);

    foreach (plan[p]) begin
      write_ceiling(plan[p]);
      run_random(75);
    end

    in_valid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (2 * NUM_SLOTS_DEF + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### priority_round_robin_picker_core.f
rtl/core/prrp_pkg.sv
rtl/core/prrp_ram.sv
rtl/core/priority_round_robin_picker_core.sv
rtl/core/prrp_checker.sv
tb/testbench.sv
